[hw/rtl/pgct_pkg.sv]
// Shared types and constants for the planar graph component tracker.
package pgct_pkg;

  localparam int CMD_W = 3;
  localparam int VA_W  = 7;
  localparam int VB_W  = 6;
  localparam int ST_W  = 2;
  localparam int VC_W  = 7;
  localparam int EC_W  = 11;
  localparam int CC_W  = 7;
  localparam int FC_W  = 11;
  localparam int AV_W  = 6;
  localparam int MD_W  = 6;
  localparam int LN_W  = 7;

  localparam logic [CMD_W-1:0] CMD_INIT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_DEGREE = 2'd3;

  localparam logic [EC_W-1:0] EDGE_LIMIT   = 11'd2047;
  localparam logic [LN_W-1:0] RESULT_LIMIT = 7'd64;
  localparam logic [MD_W-1:0] MAX_DEG_RST  = 6'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_INIT, OP_ADDV, OP_BAD,
    OP_E_RD, OP_E_CHK, OP_E_W1, OP_E_W2, OP_OUT_SIMPLE,
    OP_Q_START, OP_Q_NEXTI, OP_Q_NEWC, OP_Q_RD, OP_Q_PROC,
    OP_Q_RESWEEP, OP_Q_MERGE, OP_OUT_QUERY,
    OP_L_START, OP_L_RD, OP_L_TAKE, OP_L_NEXT, OP_L_FINAL
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ST_W-1:0]  edge_code;
    logic             self_loop;
    logic             i_done;
    logic             seen_i;
    logic             v_done;
    logic             grew;
    logic             alive;
    logic             held_v;
    logic             n_full;
    logic             out_free;
  } dp_sts_t;

endpackage

[hw/rtl/pgct_ifs.sv]
// Channel interfaces: command input, result output and configuration write.
interface pgct_in_if import pgct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VA_W-1:0]  vertex_a;
  logic [VB_W-1:0]  vertex_b;
  modport source (output valid, cmd, vertex_a, vertex_b, input ready);
  modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

interface pgct_out_if import pgct_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic [VC_W-1:0] vertex_count;
  logic [EC_W-1:0] edge_count;
  logic [CC_W-1:0] component_count;
  logic [FC_W-1:0] face_count;
  logic [AV_W-1:0] alive_vertex;
  logic            alive_valid;
  logic            last;
  modport source (output valid, status, vertex_count, edge_count, component_count,
                  face_count, alive_vertex, alive_valid, last, input ready);
  modport sink   (input valid, status, vertex_count, edge_count, component_count,
                  face_count, alive_vertex, alive_valid, last, output ready);
endinterface

interface pgct_cfg_if import pgct_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MD_W-1:0] max_degree;
  modport source (output valid, max_degree, input ready);
  modport sink   (input valid, max_degree, output ready);
endinterface

[hw/rtl/pgct_ctrl.sv]
// Sequencer: walks each command through the datapath operations.
module pgct_ctrl import pgct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_op_t  op
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_E_CHK, S_E_W1, S_E_W2, S_OUT,
    S_Q_SCAN, S_Q_RD, S_Q_PROC, S_Q_OUT,
    S_L_SCAN, S_L_CHK, S_L_END
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.cmd)
          CMD_INIT:       begin op = OP_INIT;    state_nxt = S_OUT;    end
          CMD_ADD_VERTEX: begin op = OP_ADDV;    state_nxt = S_OUT;    end
          CMD_ADD_EDGE:   begin op = OP_E_RD;    state_nxt = S_E_CHK;  end
          CMD_QUERY:      begin op = OP_Q_START; state_nxt = S_Q_SCAN; end
          CMD_LIST:       begin op = OP_L_START; state_nxt = S_L_SCAN; end
          default:        begin op = OP_BAD;     state_nxt = S_OUT;    end
        endcase
      end
      S_E_CHK: begin
        op        = OP_E_CHK;
        state_nxt = (sts.edge_code == ST_OK) ? S_E_W1 : S_OUT;
      end
      S_E_W1: begin
        op        = OP_E_W1;
        state_nxt = sts.self_loop ? S_OUT : S_E_W2;
      end
      S_E_W2: begin
        op        = OP_E_W2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          op        = OP_OUT_SIMPLE;
          state_nxt = S_IDLE;
        end
      end
      S_Q_SCAN: begin
        if (sts.i_done) begin
          state_nxt = S_Q_OUT;
        end else if (sts.seen_i) begin
          op = OP_Q_NEXTI;
        end else begin
          op        = OP_Q_NEWC;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        if (sts.v_done) begin
          if (sts.grew) begin
            op = OP_Q_RESWEEP;
          end else begin
            op        = OP_Q_MERGE;
            state_nxt = S_Q_SCAN;
          end
        end else begin
          op        = OP_Q_RD;
          state_nxt = S_Q_PROC;
        end
      end
      S_Q_PROC: begin
        op        = OP_Q_PROC;
        state_nxt = S_Q_RD;
      end
      S_Q_OUT: begin
        if (sts.out_free) begin
          op        = OP_OUT_QUERY;
          state_nxt = S_IDLE;
        end
      end
      S_L_SCAN: begin
        if (sts.i_done || sts.n_full) begin
          state_nxt = S_L_END;
        end else begin
          op        = OP_L_RD;
          state_nxt = S_L_CHK;
        end
      end
      S_L_CHK: begin
        if (!sts.alive) begin
          op        = OP_L_NEXT;
          state_nxt = S_L_SCAN;
        end else if (!sts.held_v || sts.out_free) begin
          op        = OP_L_TAKE;
          state_nxt = S_L_SCAN;
        end
      end
      S_L_END: begin
        if (sts.out_free) begin
          op        = OP_L_FINAL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/pgct_dp.sv]
// Datapath: graph store, edge checks, component sweep, alive list and result register.
module pgct_dp import pgct_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int DEGREE_BITS  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_op_t            op,
  output dp_sts_t           sts,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [VA_W-1:0]   in_vertex_a,
  input  logic [VB_W-1:0]   in_vertex_b,
  pgct_cfg_if.sink          cfg,
  pgct_out_if.source        out
);

  localparam int MAXV = MAX_VERTICES;
  localparam int DB   = DEGREE_BITS;
  localparam int VW   = (MAXV > 1) ? $clog2(MAXV) : 1;
  localparam int NVW  = $clog2(MAXV + 1);
  localparam logic [NVW-1:0] NV_MAX     = NVW'(MAXV);
  localparam logic [DB-1:0]  DEG_LIM    = '1;
  localparam logic [DB-1:0]  DEG_LIM_M2 = DEG_LIM - DB'(2);
  localparam logic [MAXV-1:0] ONE       = MAXV'(1);

  logic [MAXV-1:0] adj_mem [MAXV];
  logic [DB-1:0]   deg_mem [MAXV];
  logic [MAXV-1:0] vld_r;

  logic [CMD_W-1:0] cmd_r;
  logic [VA_W-1:0]  a_r;
  logic [VB_W-1:0]  b_r;
  logic [NVW-1:0]   nv_r;
  logic [EC_W-1:0]  edges_r;
  logic [MD_W-1:0]  max_deg_r;
  logic [ST_W-1:0]  stat_r;

  logic [MAXV-1:0] rd0_row_r, rd1_row_r;
  logic [DB-1:0]   rd0_deg_r, rd1_deg_r;

  logic [NVW-1:0]  i_r, v_r, comp_r;
  logic [MAXV-1:0] seen_r, reach_r;
  logic            grew_r;
  logic [LN_W-1:0] n_r;
  logic [VW-1:0]   held_idx_r;
  logic            held_v_r;

  logic            out_valid_r;
  logic [ST_W-1:0] out_status_r;
  logic [VC_W-1:0] out_nv_r;
  logic [EC_W-1:0] out_edges_r;
  logic [CC_W-1:0] out_comp_r;
  logic [FC_W-1:0] out_face_r;
  logic [AV_W-1:0] out_alive_r;
  logic            out_alive_v_r;
  logic            out_last_r;

  logic [VW-1:0]   a_idx, b_idx, i_idx, v_idx, ra0, wa;
  logic [MAXV-1:0] wrow, reach_nxt;
  logic [DB-1:0]   wdeg;
  logic            mem_we, rd_en, self_loop, a_over, b_over, out_free, load_out;
  logic [ST_W-1:0] edge_code;
  logic [FC_W-1:0] face;

  assign a_idx = VW'(a_r);
  assign b_idx = VW'(b_r);
  assign i_idx = i_r[VW-1:0];
  assign v_idx = v_r[VW-1:0];

  assign self_loop = (a_r == {1'b0, b_r});
  assign a_over    = self_loop ? (rd0_deg_r > DEG_LIM_M2) : (rd0_deg_r == DEG_LIM);
  assign b_over    = (rd1_deg_r == DEG_LIM);

  always_comb begin
    if (a_r >= nv_r || b_r >= nv_r) begin
      edge_code = ST_RANGE;
    end else if (edges_r >= EDGE_LIMIT) begin
      edge_code = ST_FULL;
    end else if (a_over || (!self_loop && b_over)) begin
      edge_code = ST_DEGREE;
    end else begin
      edge_code = ST_OK;
    end
  end

  assign out_free  = !out_valid_r || out.ready;
  assign load_out  = (op == OP_OUT_SIMPLE) || (op == OP_OUT_QUERY) || (op == OP_L_FINAL) ||
                     ((op == OP_L_TAKE) && held_v_r);
  assign face      = FC_W'(1) + FC_W'(comp_r) + edges_r - FC_W'(nv_r);
  assign reach_nxt = reach_r | rd0_row_r;

  always_comb begin
    sts.cmd       = cmd_r;
    sts.edge_code = edge_code;
    sts.self_loop = self_loop;
    sts.i_done    = (i_r >= nv_r);
    sts.seen_i    = seen_r[i_idx];
    sts.v_done    = (v_r >= nv_r);
    sts.grew      = grew_r;
    sts.alive     = (rd0_deg_r < max_deg_r);
    sts.held_v    = held_v_r;
    sts.n_full    = (n_r == RESULT_LIMIT);
    sts.out_free  = out_free;
  end

  // store write port: first edge end, then second unless the edge is a self-loop
  always_comb begin
    mem_we = 1'b0;
    wa     = a_idx;
    wrow   = rd0_row_r | (ONE << b_idx);
    wdeg   = rd0_deg_r + (self_loop ? DB'(2) : DB'(1));
    case (op)
      OP_E_W1: mem_we = 1'b1;
      OP_E_W2: begin
        mem_we = 1'b1;
        wa     = b_idx;
        wrow   = rd1_row_r | (ONE << a_idx);
        wdeg   = rd1_deg_r + DB'(1);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    rd_en = 1'b1;
    case (op)
      OP_E_RD: ra0 = a_idx;
      OP_Q_RD: ra0 = v_idx;
      OP_L_RD: ra0 = i_idx;
      default: begin
        ra0   = i_idx;
        rd_en = 1'b0;
      end
    endcase
  end

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[wa] <= wrow;
      deg_mem[wa] <= wdeg;
    end
    if (rd_en) begin
      rd0_row_r <= vld_r[ra0] ? adj_mem[ra0] : '0;
      rd0_deg_r <= vld_r[ra0] ? deg_mem[ra0] : '0;
      rd1_row_r <= vld_r[b_idx] ? adj_mem[b_idx] : '0;
      rd1_deg_r <= vld_r[b_idx] ? deg_mem[b_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= '0;
      edges_r     <= '0;
      max_deg_r   <= MAX_DEG_RST;
      vld_r       <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.valid) max_deg_r <= cfg.max_degree;
      if (load_out) out_valid_r <= 1'b1;
      else if (out.ready) out_valid_r <= 1'b0;
      case (op)
        OP_LATCH: begin
          cmd_r <= in_cmd;
          a_r   <= in_vertex_a;
          b_r   <= in_vertex_b;
        end
        OP_INIT: begin
          nv_r    <= (a_r > MAXV) ? NV_MAX : NVW'(a_r);
          vld_r   <= '0;
          edges_r <= '0;
          stat_r  <= ST_OK;
        end
        OP_ADDV: begin
          if (nv_r >= NV_MAX) begin
            stat_r <= ST_FULL;
          end else begin
            nv_r   <= nv_r + NVW'(1);
            stat_r <= ST_OK;
          end
        end
        OP_BAD:   stat_r <= ST_RANGE;
        OP_E_CHK: stat_r <= edge_code;
        OP_E_W1: begin
          vld_r[a_idx] <= 1'b1;
          edges_r      <= edges_r + EC_W'(1);
        end
        OP_E_W2: vld_r[b_idx] <= 1'b1;
        OP_Q_START: begin
          seen_r <= '0;
          i_r    <= '0;
          comp_r <= '0;
        end
        OP_Q_NEXTI: i_r <= i_r + NVW'(1);
        OP_Q_NEWC: begin
          comp_r  <= comp_r + NVW'(1);
          reach_r <= ONE << i_idx;
          v_r     <= '0;
          grew_r  <= 1'b0;
        end
        OP_Q_PROC: begin
          if (reach_r[v_idx] && (reach_nxt != reach_r)) begin
            reach_r <= reach_nxt;
            grew_r  <= 1'b1;
          end
          v_r <= v_r + NVW'(1);
        end
        OP_Q_RESWEEP: begin
          v_r    <= '0;
          grew_r <= 1'b0;
        end
        OP_Q_MERGE: begin
          seen_r <= seen_r | reach_r;
          i_r    <= i_r + NVW'(1);
        end
        OP_L_START: begin
          i_r      <= '0;
          n_r      <= '0;
          held_v_r <= 1'b0;
        end
        OP_L_TAKE: begin
          held_idx_r <= i_idx;
          held_v_r   <= 1'b1;
          n_r        <= n_r + LN_W'(1);
          i_r        <= i_r + NVW'(1);
        end
        OP_L_NEXT: i_r <= i_r + NVW'(1);
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= ST_OK;
      out_nv_r      <= VC_W'(nv_r);
      out_edges_r   <= edges_r;
      out_comp_r    <= '0;
      out_face_r    <= '0;
      out_alive_r   <= '0;
      out_alive_v_r <= 1'b0;
      out_last_r    <= 1'b1;
      case (op)
        OP_OUT_SIMPLE: out_status_r <= stat_r;
        OP_OUT_QUERY: begin
          out_comp_r <= CC_W'(comp_r);
          out_face_r <= face;
        end
        OP_L_TAKE: begin
          out_alive_r   <= AV_W'(held_idx_r);
          out_alive_v_r <= 1'b1;
          out_last_r    <= 1'b0;
        end
        OP_L_FINAL: begin
          out_alive_r   <= held_v_r ? AV_W'(held_idx_r) : '0;
          out_alive_v_r <= held_v_r;
        end
        default: ;
      endcase
    end
  end

  assign cfg.ready           = 1'b1;
  assign out.valid           = out_valid_r;
  assign out.status          = out_status_r;
  assign out.vertex_count    = out_nv_r;
  assign out.edge_count      = out_edges_r;
  assign out.component_count = out_comp_r;
  assign out.face_count      = out_face_r;
  assign out.alive_vertex    = out_alive_r;
  assign out.alive_valid     = out_alive_v_r;
  assign out.last            = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out.ready))
    else $error("result word overwritten before it was taken");

  a_nv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r <= NV_MAX)
    else $error("vertex count beyond store size");

  a_w2_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_E_W2) |-> !self_loop)
    else $error("second end written for a self-loop");

  a_merge_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_Q_MERGE) |=> (seen_r == ($past(seen_r) | $past(reach_r))))
    else $error("component not merged into seen set");

endmodule

[hw/rtl/planar_graph_component_tracker_unit.sv]
// Init, add vertex and unknown codes are decoded, then give their result word; add edge
// reads and checks both ends, then unless refused writes one end for a self-loop, else both.
// Query scans every vertex and, per new component, repeats sweeps over all vertices
// until a sweep adds nothing.
// List reads each vertex in turn and waits while the sink holds a word back.
// One command in flight at a time. Reset is synchronous, active low; store cleared via valid bits.
module planar_graph_component_tracker_unit import pgct_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int DEGREE_BITS  = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  pgct_in_if.sink    in_ch,
  pgct_out_if.source out_ch,
  pgct_cfg_if.sink   cfg_ch
);

  dp_op_t  op;
  dp_sts_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  pgct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  pgct_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEGREE_BITS  (DEGREE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .sts         (sts),
    .in_cmd      (in_ch.cmd),
    .in_vertex_a (in_ch.vertex_a),
    .in_vertex_b (in_ch.vertex_b),
    .cfg         (cfg_ch),
    .out         (out_ch)
  );

endmodule
